>>> rtl/core/spr_tile_pkg.sv
// Shared types and constants for the sprite entry to tile command expander.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package spr_tile_pkg;

	// Field positions in the Y attribute word
	localparam int unsigned AY_FLASH_BIT = 12;
	localparam int unsigned AY_FLIPX_BIT = 13;
	localparam int unsigned AY_FLIPY_BIT = 14;

	// Position limits of the sprite list format
	localparam logic [8:0]         X_WRAP_LIMIT = 9'd320;  // raw x at or above wraps left
	localparam logic signed [10:0] X_ORIGIN     = 11'sd304;
	localparam logic signed [10:0] Y_ORIGIN     = 11'sd240;
	localparam logic signed [10:0] X_VISIBLE    = 11'sd320;
	localparam logic signed [10:0] X_WRAP_SPAN  = 11'sd512;

	// Width of the tile row index inside a column (up to eight rows)
	localparam int unsigned ROW_W = 3;

	// One classified entry, handed from the front end to the expander
	typedef struct packed {
		logic [15:0]      code_base;  // code with the row bits forced
		logic             code_up;    // codes ascend with the row index
		logic [ROW_W-1:0] rows_m;     // highest row index
		logic [4:0]       colour;
		logic             flip_x;
		logic             flip_y;
		logic [9:0]       pos_x;
		logic [9:0]       pos_y;      // y of row zero
		logic             y_up;       // rows step down the screen
	} entry_t;

endpackage

>>> rtl/core/spr_tile_front.sv
// Front end: accepts sprite entries, drops the ones that draw nothing and
// precomputes per-entry fields. Depends on spr_tile_pkg.
`timescale 1ns / 1ps

module spr_tile_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 screen_flipped,
	input  logic                 push,
	output logic                 full,
	input  logic [15:0]          attr_word_y,
	input  logic [15:0]          tile_word,
	input  logic [15:0]          attr_word_x,
	input  logic                 frame_odd,
	input  logic                 q_full,
	output logic                 q_push,
	output spr_tile_pkg::entry_t q_entry
);
	import spr_tile_pkg::*;

	logic               valid_s1;
	entry_t             entry_s1;
	logic               take;
	logic               keep;
	logic [1:0]         height;
	logic [ROW_W-1:0]   rows_m;
	logic [15:0]        mask16;
	logic signed [10:0] xs;
	logic signed [10:0] ys;
	logic signed [10:0] xm;
	logic signed [10:0] ym;
	logic               fy_raw;
	entry_t             entry_d;

	// Decode and classify the incoming word
	always_comb begin
		height = attr_word_y[10:9];
		case (height)
			2'd0:    rows_m = ROW_W'(0);
			2'd1:    rows_m = ROW_W'(1);
			2'd2:    rows_m = ROW_W'(3);
			default: rows_m = ROW_W'(7);
		endcase
		mask16 = {{(16 - ROW_W){1'b0}}, rows_m};
		fy_raw = attr_word_y[AY_FLIPY_BIT];

		// Signed positions: x wraps at 320, y is a 9-bit two's complement
		xs = {2'b00, attr_word_x[8:0]};
		if (attr_word_x[8:0] >= X_WRAP_LIMIT) begin
			xs = xs - X_WRAP_SPAN;
		end
		ys = {{2{attr_word_y[8]}}, attr_word_y[8:0]};
		xm = X_ORIGIN - xs;
		ym = Y_ORIGIN - ys;

		keep = (tile_word != 16'd0)
			&& !(attr_word_y[AY_FLASH_BIT] && frame_odd)
			&& !(xm > X_VISIBLE);

		entry_d.code_base = fy_raw ? (tile_word & ~mask16) : (tile_word | mask16);
		entry_d.code_up   = fy_raw;
		entry_d.rows_m    = rows_m;
		entry_d.colour    = attr_word_x[13:9];
		entry_d.flip_x    = attr_word_y[AY_FLIPX_BIT] ^ screen_flipped;
		entry_d.flip_y    = fy_raw ^ screen_flipped;
		entry_d.pos_x     = screen_flipped ? xs[9:0] : xm[9:0];
		entry_d.pos_y     = screen_flipped ? ys[9:0] : ym[9:0];
		entry_d.y_up      = screen_flipped;
	end

	assign full = valid_s1 && q_full;
	assign take = push && !full;

	// Hold the classified word until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (valid_s1 && !q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_d;
		end
	end

	assign q_push  = valid_s1;
	assign q_entry = entry_s1;

endmodule

>>> rtl/core/spr_tile_queue.sv
// Short queue of classified entries between the front end and the expander.
// Depends on spr_tile_pkg.
`timescale 1ns / 1ps

module spr_tile_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  spr_tile_pkg::entry_t wr_data,
	output logic                 q_full,
	input  logic                 rd_en,
	output spr_tile_pkg::entry_t rd_data,
	output logic                 q_empty
);
	import spr_tile_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == CW'(0));
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/spr_tile_back.sv
// Back end: expands the entry at the queue head into one tile command per
// cycle while the output register is free or popped, and holds it there. Depends on spr_tile_pkg.
`timescale 1ns / 1ps

module spr_tile_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spr_tile_pkg::entry_t head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [15:0]          draw_code,
	output logic [4:0]           draw_colour,
	output logic                 draw_flip_x,
	output logic                 draw_flip_y,
	output logic signed [9:0]    draw_x,
	output logic signed [9:0]    draw_y,
	output logic                 last_tile
);
	import spr_tile_pkg::*;

	logic             busy_q;
	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] row;
	logic             out_valid_q;
	logic             advance;
	logic             emit;
	logic [15:0]      code_d;
	logic [9:0]       y_off;
	logic [9:0]       y_d;

	assign advance = !out_valid_q || pop;
	assign emit    = advance && !q_empty;
	assign row     = busy_q ? row_q : head.rows_m;
	assign q_pop   = emit && (row == ROW_W'(0));
	assign empty   = !out_valid_q;

	// Form the command for the current row
	always_comb begin
		code_d = head.code_up ? head.code_base + {{(16 - ROW_W){1'b0}}, row}
			: head.code_base - {{(16 - ROW_W){1'b0}}, row};
		y_off  = {{(6 - ROW_W){1'b0}}, row, 4'b0000};
		y_d    = head.y_up ? head.pos_y + y_off : head.pos_y - y_off;
	end

	// Step the row counter down to zero, then release the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				busy_q      <= (row != ROW_W'(0));
				row_q       <= row - ROW_W'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (emit) begin
			draw_code   <= code_d;
			draw_colour <= head.colour;
			draw_flip_x <= head.flip_x;
			draw_flip_y <= head.flip_y;
			draw_x      <= head.pos_x;
			draw_y      <= y_d;
			last_tile   <= (row == ROW_W'(0));
		end
	end

endmodule

>>> rtl/core/sprite_entry_to_tile_commands_core.sv
// Sprite entry to tile command expander, top level.
// Path: a pushed entry passes the front end register, a queue slot and the output register to reach the outputs.
// Throughput: one command per cycle from the expander's row counter while pop keeps the
// output free; an entry of 2^h rows gives 2^h commands (1 to 8); empty or hidden entries never reach the queue.
// Reset: arst_n clears the queue, the front end's valid flag, the row counter and screen_flipped to 0.
`timescale 1ns / 1ps

module sprite_entry_to_tile_commands_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              push,
	output logic              full,
	input  logic [15:0]       attr_word_y,
	input  logic [15:0]       tile_word,
	input  logic [15:0]       attr_word_x,
	input  logic              frame_odd,
	output logic              empty,
	input  logic              pop,
	output logic [15:0]       draw_code,
	output logic [4:0]        draw_colour,
	output logic              draw_flip_x,
	output logic              draw_flip_y,
	output logic signed [9:0] draw_x,
	output logic signed [9:0] draw_y,
	output logic              last_tile
);
	import spr_tile_pkg::*;

	logic   screen_flipped_q;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t q_in;
	entry_t q_head;

	assign cfg_ready = 1'b1;

	// Hold the screen flip setting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_flipped_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			screen_flipped_q <= cfg_data;
		end
	end

	spr_tile_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.screen_flipped (screen_flipped_q),
		.push           (push),
		.full           (full),
		.attr_word_y    (attr_word_y),
		.tile_word      (tile_word),
		.attr_word_x    (attr_word_x),
		.frame_odd      (frame_odd),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_in)
	);

	spr_tile_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_in),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.q_empty (q_empty)
	);

	spr_tile_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.draw_code   (draw_code),
		.draw_colour (draw_colour),
		.draw_flip_x (draw_flip_x),
		.draw_flip_y (draw_flip_y),
		.draw_x      (draw_x),
		.draw_y      (draw_y),
		.last_tile   (last_tile)
	);

endmodule
